// File: rtl/rpgsa_pkg.sv
// ----------------------------------------------------------------------------
// rpgsa_pkg
// shared widths, codes and control types of the gradient scatter-add block
// ----------------------------------------------------------------------------
package rpgsa_pkg;

    localparam int MAP_ENTRIES_DEF = 65536;

    localparam int PLANE_W     = 17;
    localparam int CHAN_CNT_W  = 10;
    localparam int POS_W       = 16;
    localparam int CHAN_W      = 9;
    localparam int DATA_W      = 32;
    localparam int STATUS_W    = 2;
    // position + channel * plane_size never exceeds 26 bits
    localparam int ADDR_FULL_W = 26;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 17;

    localparam logic [PLANE_W-1:0]    PLANE_SIZE_RST    = PLANE_W'(1024);
    localparam logic [CHAN_CNT_W-1:0] CHANNEL_COUNT_RST = CHAN_CNT_W'(64);

    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_SIZE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'b1;

    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ACCUM = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SKIP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_READ  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic clear;      // write zero at the clearing counter
        logic load;       // capture the input item
        logic addr_calc;  // form flat address and range flags
        logic rd_issue;   // read the map entry, settle status
        logic finish;     // write back and load the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_dp_stat;

endpackage

// File: rtl/roi_pool_gradient_scatter_add_top.sv
// ----------------------------------------------------------------------------
// roi_pool_gradient_scatter_add_top
// roi max-pool backward: saturating gradient scatter-add into a feature map
// ----------------------------------------------------------------------------
// items: one at a time; a new one is taken only once the last is written back
// pace: set by the read-modify-write of the
//   single map memory (address step, registered read, write-back)
// reset: synchronous, active low; then a clearing pass writes zero to each
//   map entry in turn with o_in_ready low; config writes are taken throughout
// ----------------------------------------------------------------------------
module roi_pool_gradient_scatter_add_top #(
    parameter int MAP_ENTRIES = rpgsa_pkg::MAP_ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [rpgsa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rpgsa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input item channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_cmd,
    input  logic                                i_mask_valid,
    input  logic [rpgsa_pkg::POS_W-1:0]         i_position,
    input  logic [rpgsa_pkg::CHAN_W-1:0]        i_channel,
    input  logic signed [rpgsa_pkg::DATA_W-1:0] i_gradient,
    // result item channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [rpgsa_pkg::STATUS_W-1:0]      o_status,
    output logic signed [rpgsa_pkg::DATA_W-1:0] o_read_value
);
    import rpgsa_pkg::*;

    // command and status between sequencer and datapath
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: clearing pass, then one item at a time through four steps
    rpgsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath: config, address unit, map ram, adder and output register;
    // the output register lets the next item in while a result waits
    rpgsa_dpath #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (i_cmd),
        .i_mask_valid (i_mask_valid),
        .i_position   (i_position),
        .i_channel    (i_channel),
        .i_gradient   (i_gradient),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .i_ctl        (w_cmd),
        .o_stat       (w_stat)
    );

endmodule

// File: rtl/rpgsa_ram.sv
// ----------------------------------------------------------------------------
// rpgsa_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module rpgsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/rpgsa_ctrl.sv
// ----------------------------------------------------------------------------
// rpgsa_ctrl
// sequencer: clearing pass, then address, read and write-back per item
// ----------------------------------------------------------------------------
module rpgsa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rpgsa_pkg::t_dp_stat i_stat,
    output rpgsa_pkg::t_dp_cmd  o_cmd
);
    import rpgsa_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_ADDR  = 5'b00100,
        S_READ  = 5'b01000,
        S_WRITE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ADDR;
                end
            end
            S_ADDR: begin
                o_cmd.addr_calc = 1'b1;
                n_state         = S_READ;
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_WRITE;
            end
            S_WRITE: begin
                // hold while the previous result is still waiting
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: rtl/rpgsa_dpath.sv
// ----------------------------------------------------------------------------
// rpgsa_dpath
// config registers, address unit, map memory, saturating adder, output stage
// ----------------------------------------------------------------------------
module rpgsa_dpath #(
    parameter int MAP_ENTRIES = rpgsa_pkg::MAP_ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rpgsa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rpgsa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_cmd,
    input  logic                                i_mask_valid,
    input  logic [rpgsa_pkg::POS_W-1:0]         i_position,
    input  logic [rpgsa_pkg::CHAN_W-1:0]        i_channel,
    input  logic signed [rpgsa_pkg::DATA_W-1:0] i_gradient,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [rpgsa_pkg::STATUS_W-1:0]      o_status,
    output logic signed [rpgsa_pkg::DATA_W-1:0] o_read_value,
    input  rpgsa_pkg::t_dp_cmd                  i_ctl,
    output rpgsa_pkg::t_dp_stat                 o_stat
);
    import rpgsa_pkg::*;

    localparam int AW = $clog2(MAP_ENTRIES);
    localparam logic [ADDR_FULL_W:0] MAP_LIMIT = (ADDR_FULL_W + 1)'(MAP_ENTRIES);
    localparam logic [AW-1:0]        CLR_LAST  = AW'(MAP_ENTRIES - 1);
    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

    // configuration
    logic [PLANE_W-1:0]    r_plane_size;
    logic [CHAN_CNT_W-1:0] r_channel_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_size    <= PLANE_SIZE_RST;
            r_channel_count <= CHANNEL_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PLANE_SIZE:    r_plane_size    <= i_cfg_data[PLANE_W-1:0];
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CHAN_CNT_W-1:0];
                default:           r_plane_size    <= r_plane_size;
            endcase
        end
    end

    // captured item
    logic                     r_cmd;
    logic                     r_mask;
    logic [POS_W-1:0]         r_pos;
    logic [CHAN_W-1:0]        r_ch;
    logic signed [DATA_W-1:0] r_grad;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= i_cmd;
            r_mask <= i_mask_valid;
            r_pos  <= i_position;
            r_ch   <= i_channel;
            r_grad <= i_gradient;
        end
    end

    // flat address and range flags
    logic [ADDR_FULL_W-1:0] w_prod;
    logic [ADDR_FULL_W-1:0] r_addr_full;
    logic                   r_pos_ok;
    logic                   r_ch_ok;

    assign w_prod = ADDR_FULL_W'(r_ch) * ADDR_FULL_W'(r_plane_size);

    always_ff @(posedge i_clk) begin
        if (i_ctl.addr_calc) begin
            r_addr_full <= w_prod + ADDR_FULL_W'(r_pos);
            r_pos_ok    <= {1'b0, r_pos} < r_plane_size;
            r_ch_ok     <= {1'b0, r_ch} < r_channel_count;
        end
    end

    // status settles while the entry is read
    logic                w_in_range;
    logic [STATUS_W-1:0] w_status;
    logic [STATUS_W-1:0] r_status;
    logic                r_mem_op;

    assign w_in_range = r_pos_ok && r_ch_ok && ({1'b0, r_addr_full} < MAP_LIMIT);

    always_comb begin
        priority if (r_cmd == CMD_ACCUM && !r_mask) begin
            w_status = ST_SKIP;
        end else if (!w_in_range) begin
            w_status = ST_RANGE;
        end else if (r_cmd == CMD_ACCUM) begin
            w_status = ST_ACCUM;
        end else begin
            w_status = ST_READ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_issue) begin
            r_status <= w_status;
            r_mem_op <= (w_status == ST_ACCUM) || (w_status == ST_READ);
        end
    end

    // clearing counter
    logic [AW-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_ctl.clear) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
        end
    end

    // map memory
    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic signed [DATA_W-1:0] w_wdata;
    logic signed [DATA_W-1:0] w_rdata;
    logic signed [DATA_W:0]   w_sum;
    logic signed [DATA_W-1:0] w_sat;

    assign w_sum = {w_rdata[DATA_W-1], w_rdata} + {r_grad[DATA_W-1], r_grad};

    always_comb begin
        if (w_sum[DATA_W] != w_sum[DATA_W-1]) begin
            w_sat = w_sum[DATA_W] ? SAT_MIN : SAT_MAX;
        end else begin
            w_sat = w_sum[DATA_W-1:0];
        end
    end

    assign w_we    = i_ctl.clear || (i_ctl.finish && r_mem_op);
    assign w_waddr = i_ctl.clear ? r_clr_cnt : r_addr_full[AW-1:0];
    // a read clears its entry for the next batch
    assign w_wdata = (i_ctl.clear || r_status == ST_READ) ? '0 : w_sat;

    rpgsa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAP_ENTRIES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_ctl.rd_issue),
        .i_raddr (r_addr_full[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // output register
    logic                     r_out_valid;
    logic [STATUS_W-1:0]      r_out_status;
    logic signed [DATA_W-1:0] r_out_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_out_status <= r_status;
            r_out_value  <= (r_status == ST_READ) ? w_rdata : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_value = r_out_value;

    assign o_stat.clear_last = (r_clr_cnt == CLR_LAST);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

endmodule

// File: rtl/rpgsa_checker.sv
// ----------------------------------------------------------------------------
// rpgsa_checker
// port-level checks on the gradient scatter-add top level, bound in below
// ----------------------------------------------------------------------------
module rpgsa_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [rpgsa_pkg::STATUS_W-1:0]      o_status,
    input logic signed [rpgsa_pkg::DATA_W-1:0] o_read_value
);
    import rpgsa_pkg::*;

    // reset starts the clearing pass: no item taken, no result shown
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("ready or valid high straight after reset");

    // one item at a time: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("item accepted while previous one still in progress");

    // only a completed read carries a value
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_READ |-> o_read_value == '0)
        else $error("non-zero read_value on a result other than read done");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_read_value))
        else $error("stalled result changed or dropped");

endmodule

bind roi_pool_gradient_scatter_add_top rpgsa_checker u_rpgsa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_status     (o_status),
    .o_read_value (o_read_value)
);
